@@ sv/qudadv_pkg.sv @@
// shared constants, types and coefficient selection for the quick upwind advection block
package qudadv_pkg;

	localparam int MAX_ROW_LENGTH = 1024;
	localparam int SAMPLE_BITS    = 32;
	localparam int DENS_ROWS      = 4;
	localparam int VEL_ROWS       = 2;
	localparam int DENS_DEPTH     = DENS_ROWS * MAX_ROW_LENGTH;
	localparam int VEL_DEPTH      = VEL_ROWS * MAX_ROW_LENGTH;
	localparam int DADDR_W        = $clog2(DENS_DEPTH);
	localparam int VADDR_W        = $clog2(VEL_DEPTH);
	localparam int COL_W          = 10;
	localparam int ROW_W          = 13;
	localparam int CELL_ROW_W     = 12;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;
	localparam int KDT_W          = 24;
	localparam int COEF_W         = 36;
	localparam int LIMB_W         = 17;
	localparam int PROD_W         = COEF_W + LIMB_W;
	localparam int ACC_W          = 88;
	localparam int FLUX_W         = 58;
	localparam int RES_W          = 60;
	localparam int MAX_HEIGHT     = 4096;

	localparam logic [CFG_IDX_W-1:0] CFG_IWIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IHEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BORDER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DTDX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DTDY    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PICK,
		ST_MAC,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PH_FX,
		PH_FY,
		PH_SX,
		PH_SY
	} phase_t;

	typedef logic [4:0][COEF_W-1:0] coef_vec_t;

	// quick coefficients in eighths of a velocity
	function automatic coef_vec_t pick_coef(input logic signed [31:0] v1,
		input logic signed [31:0] v2);
		logic signed [COEF_W-1:0] w1;
		logic signed [COEF_W-1:0] w2;
		logic signed [COEF_W-1:0] t1;
		logic signed [COEF_W-1:0] t2;
		logic signed [COEF_W-1:0] s1;
		logic signed [COEF_W-1:0] s2;
		coef_vec_t c;
		w1 = {{(COEF_W-32){v1[31]}}, v1};
		w2 = {{(COEF_W-32){v2[31]}}, v2};
		t1 = (w1 <<< 1) + w1;
		t2 = (w2 <<< 1) + w2;
		s1 = t1 <<< 1;
		s2 = t2 <<< 1;
		c = '0;
		if (!v1[31] && !v2[31]) begin
			c[0] = w1;
			c[1] = -w2 - s1;
			c[2] = s2 - t1;
			c[3] = t2;
		end else if ((v1[31] || v1 == 32'sd0) && (v2[31] || v2 == 32'sd0)) begin
			c[1] = -t1;
			c[2] = t2 - s1;
			c[3] = s2 + w1;
			c[4] = -w2;
		end else if (v1[31]) begin
			c[1] = -w2 - t1;
			c[2] = s2 - s1;
			c[3] = t2 + w1;
		end else begin
			c[0] = w1;
			c[1] = -s1;
			c[2] = t2 - t1;
			c[3] = s2;
			c[4] = -w2;
		end
		return c;
	endfunction

	// 16-bit slice of a 32-bit sample as a signed partial-product operand
	function automatic logic signed [LIMB_W-1:0] rho_limb(input logic [31:0] x,
		input logic sel);
		logic signed [LIMB_W-1:0] l;
		if (sel)
			l = {x[31], x[31:16]};
		else
			l = {1'b0, x[15:0]};
		return l;
	endfunction

	// 16-bit slice of a flux sum as a signed partial-product operand
	function automatic logic signed [LIMB_W-1:0] flux_limb(input logic [FLUX_W-1:0] f,
		input logic [1:0] sel);
		logic [63:0] fe;
		logic signed [LIMB_W-1:0] l;
		fe = {{(64-FLUX_W){f[FLUX_W-1]}}, f};
		case (sel)
			2'd0: l = {1'b0, fe[15:0]};
			2'd1: l = {1'b0, fe[31:16]};
			2'd2: l = {1'b0, fe[47:32]};
			default: l = {fe[63], fe[63:48]};
		endcase
		return l;
	endfunction

endpackage

@@ sv/qudadv_ram.sv @@
// generic simple dual-port ram with registered read
module qudadv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/quick_upwind_density_advection.sv @@
// quick upwind density advection stencil engine, top level
//
//  channel  direction  handshake               word
//  cfg      in         cfg_we                  cfg_index, cfg_wdata
//  in       in         in_valid / in_stall     density, face velocities, frame_start
//  out      out        out_valid / out_stall   new density, cell position, frame_done
//
// a border sample (no result) is written to the line memories and the engine stays idle
// an interior cell takes eight reads through the single density read port,
// then 28 passes through the one shared 36x17 multiply-accumulate unit
// reset clears counters and control and loads configuration defaults; line memories are not cleared
// the next sample is taken while a result waits under out_stall
module quick_upwind_density_advection (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qudadv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qudadv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [31:0]                   density_sample,
	input  logic signed [31:0]                   xvel_left_face,
	input  logic signed [31:0]                   yvel_lower_face,
	input  logic                                 frame_start,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [31:0]                   new_density,
	output logic [qudadv_pkg::COL_W-1:0]         cell_col,
	output logic [qudadv_pkg::CELL_ROW_W-1:0]    cell_row,
	output logic                                 frame_done
);
	import qudadv_pkg::*;

	// configuration
	logic [COL_W-1:0]  iw_q;
	logic [ROW_W-1:0]  ih_q;
	logic [2:0]        bw_q;
	logic [KDT_W-1:0]  kdx_q;
	logic [KDT_W-1:0]  kdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q  <= 10'd64;
			ih_q  <= 13'd64;
			bw_q  <= 3'd2;
			kdx_q <= 24'd6554;
			kdy_q <= 24'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IWIDTH:  iw_q  <= cfg_wdata[COL_W-1:0];
				CFG_IHEIGHT: ih_q  <= cfg_wdata[ROW_W-1:0];
				CFG_BORDER:  bw_q  <= cfg_wdata[2:0];
				CFG_DTDX:    kdx_q <= cfg_wdata[KDT_W-1:0];
				CFG_DTDY:    kdy_q <= cfg_wdata[KDT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [2:0]  bd;
	logic [3:0]  b2;
	logic [10:0] iw_cap;
	logic [10:0] iw_e;
	logic [12:0] ih_e;
	logic [10:0] pw;
	logic [12:0] ph;

	always_comb begin
		if (bw_q < 3'd2)
			bd = 3'd2;
		else if (bw_q > 3'd4)
			bd = 3'd4;
		else
			bd = bw_q;
		b2     = {bd, 1'b0};
		iw_cap = 11'(MAX_ROW_LENGTH) - {7'd0, b2};
		iw_e   = ({1'b0, iw_q} > iw_cap) ? iw_cap : {1'b0, iw_q};
		ih_e   = (ih_q > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : ih_q;
		pw     = iw_e + {7'd0, b2};
		ph     = ih_e + {9'd0, b2};
	end

	// position counters
	state_t            st_q, st_d;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  cur_c;
	logic [ROW_W-1:0]  cur_r;
	logic [10:0]       nc;
	logic [13:0]       nr;
	logic [ROW_W-1:0]  rr;
	logic              emit;
	logic [COL_W-1:0]  ci;
	logic [ROW_W-1:0]  cj;
	logic              cdone;
	logic              in_acc;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && (st_q == ST_IDLE);

	always_comb begin
		cur_c = frame_start ? '0 : col_q;
		cur_r = frame_start ? '0 : row_q;
		nc    = {1'b0, cur_c} + 11'd1;
		nr    = {1'b0, cur_r} + 14'd1;
		rr    = cur_r - 13'd2;
		emit  = (cur_r >= 13'd2) && (rr >= {10'd0, bd}) &&
			({1'b0, rr} < {11'd0, bd} + {1'b0, ih_e}) &&
			({1'b0, cur_c} >= {8'd0, bd}) &&
			({1'b0, cur_c} < {8'd0, bd} + iw_e);
		ci    = cur_c - {7'd0, bd};
		cj    = rr - {10'd0, bd};
		cdone = ({1'b0, ci} == iw_e - 11'd1) && (cj == ih_e - 13'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (nc >= pw) begin
				col_q <= '0;
				row_q <= (nr >= {1'b0, ph}) ? '0 : nr[ROW_W-1:0];
			end else begin
				col_q <= nc[COL_W-1:0];
				row_q <= cur_r;
			end
		end
	end

	// held word of the cell in progress
	logic signed [31:0]      rho_q;
	logic [31:0]             u_q;
	logic [31:0]             v_q;
	logic [COL_W-1:0]        ic_q;
	logic [1:0]              slot_q;
	logic [COL_W-1:0]        ci_q;
	logic [CELL_ROW_W-1:0]   cj_q;
	logic                    cdone_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rho_q   <= density_sample;
			u_q     <= xvel_left_face;
			v_q     <= yvel_lower_face;
			ic_q    <= cur_c;
			slot_q  <= cur_r[1:0];
			ci_q    <= ci;
			cj_q    <= cj[CELL_ROW_W-1:0];
			cdone_q <= cdone;
		end
	end

	// line memories
	logic                fin_go;
	logic                mem_we;
	logic [DADDR_W-1:0]  d_waddr;
	logic [VADDR_W-1:0]  v_waddr;
	logic [31:0]         d_wdata;
	logic [31:0]         x_wdata;
	logic [31:0]         y_wdata;
	logic [DADDR_W-1:0]  d_raddr;
	logic [VADDR_W-1:0]  x_raddr;
	logic [VADDR_W-1:0]  y_raddr;
	logic [31:0]         d_rdata;
	logic [31:0]         x_rdata;
	logic [31:0]         y_rdata;
	logic [2:0]          rd_idx_q;
	logic                rd_go;

	always_comb begin
		mem_we = (in_acc && !emit) || fin_go;
		if (fin_go) begin
			d_waddr = {slot_q, ic_q};
			v_waddr = {slot_q[0], ic_q};
			d_wdata = rho_q;
			x_wdata = u_q;
			y_wdata = v_q;
		end else begin
			d_waddr = {cur_r[1:0], cur_c};
			v_waddr = {cur_r[0], cur_c};
			d_wdata = density_sample;
			x_wdata = xvel_left_face;
			y_wdata = yvel_lower_face;
		end
		case (rd_idx_q)
			3'd5: d_raddr = {slot_q, ic_q};
			3'd6: d_raddr = {slot_q + 2'd1, ic_q};
			3'd7: d_raddr = {slot_q + 2'd3, ic_q};
			default: d_raddr = {slot_q + 2'd2, ic_q + {7'd0, rd_idx_q} - 10'd2};
		endcase
		if (rd_idx_q[0]) begin
			x_raddr = {slot_q[0], ic_q + 10'd1};
			y_raddr = {~slot_q[0], ic_q};
		end else begin
			x_raddr = {slot_q[0], ic_q};
			y_raddr = {slot_q[0], ic_q};
		end
	end

	qudadv_ram #(.WIDTH(32), .DEPTH(DENS_DEPTH)) u_dens_ram (
		.clk(clk), .we(mem_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	qudadv_ram #(.WIDTH(32), .DEPTH(VEL_DEPTH)) u_xvel_ram (
		.clk(clk), .we(mem_we), .waddr(v_waddr), .wdata(x_wdata),
		.raddr(x_raddr), .rdata(x_rdata)
	);

	qudadv_ram #(.WIDTH(32), .DEPTH(VEL_DEPTH)) u_yvel_ram (
		.clk(clk), .we(mem_we), .waddr(v_waddr), .wdata(y_wdata),
		.raddr(y_raddr), .rdata(y_rdata)
	);

	// read capture
	logic        rd_vld_s1;
	logic [2:0]  rd_idx_s1;
	logic [31:0] dw_q [8];
	logic [31:0] xv_q [2];
	logic [31:0] yv_q [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= rd_go;
			rd_idx_s1 <= rd_idx_q;
			if (rd_go)
				rd_idx_q <= rd_idx_q + 3'd1;
			else
				rd_idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			dw_q[rd_idx_s1] <= d_rdata;
			if (rd_idx_s1 < 3'd2) begin
				xv_q[rd_idx_s1[0]] <= x_rdata;
				yv_q[rd_idx_s1[0]] <= y_rdata;
			end
		end
	end

	// multiply-accumulate sequencing
	phase_t                    phase_q;
	logic [3:0]                step_q;
	logic [3:0]                n_steps;
	logic                      issue;
	logic                      ph_end;
	coef_vec_t                 cx_q;
	coef_vec_t                 cy_q;
	logic [31:0]               win [5];
	logic [31:0]               colv [5];
	logic [2:0]                kk;
	logic signed [COEF_W-1:0]  a_op;
	logic signed [LIMB_W-1:0]  b_op;
	logic [1:0]                sh;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [1:0]                sh_s1;
	logic                      prod_vld_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   pext;
	logic [FLUX_W-1:0]         fx_q;
	logic [FLUX_W-1:0]         fy_q;
	logic signed [FLUX_W-1:0]  sx_q;
	logic signed [FLUX_W-1:0]  sy_q;

	always_comb begin
		for (int k = 0; k < 5; k++)
			win[k] = dw_q[k];
		colv[0] = dw_q[5];
		colv[1] = dw_q[6];
		colv[2] = dw_q[2];
		colv[3] = dw_q[7];
		colv[4] = rho_q;
		n_steps = (phase_q == PH_FX || phase_q == PH_FY) ? 4'd10 : 4'd4;
		issue   = (st_q == ST_MAC) && (step_q != n_steps);
		ph_end  = (st_q == ST_MAC) && (step_q == n_steps) && !prod_vld_s1;
		kk      = (step_q[3:1] > 3'd4) ? 3'd4 : step_q[3:1];
		case (phase_q)
			PH_FX: begin
				a_op = $signed(cx_q[kk]);
				b_op = rho_limb(win[kk], step_q[0]);
				sh   = {1'b0, step_q[0]};
			end
			PH_FY: begin
				a_op = $signed(cy_q[kk]);
				b_op = rho_limb(colv[kk], step_q[0]);
				sh   = {1'b0, step_q[0]};
			end
			PH_SX: begin
				a_op = $signed({{(COEF_W-KDT_W){1'b0}}, kdx_q});
				b_op = flux_limb(fx_q, step_q[1:0]);
				sh   = step_q[1:0];
			end
			default: begin
				a_op = $signed({{(COEF_W-KDT_W){1'b0}}, kdy_q});
				b_op = flux_limb(fy_q, step_q[1:0]);
				sh   = step_q[1:0];
			end
		endcase
		case (sh_s1)
			2'd0: pext = ACC_W'(prod_s1);
			2'd1: pext = ACC_W'(prod_s1) <<< 16;
			2'd2: pext = ACC_W'(prod_s1) <<< 32;
			default: pext = ACC_W'(prod_s1) <<< 48;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FX;
			step_q      <= '0;
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= issue;
			if (st_q == ST_PICK) begin
				phase_q <= PH_FX;
				step_q  <= '0;
			end else if (ph_end) begin
				phase_q <= phase_t'(phase_q + 2'd1);
				step_q  <= '0;
			end else if (issue) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_op * b_op;
		sh_s1   <= sh;
		if (st_q == ST_PICK) begin
			cx_q <= pick_coef(xv_q[0], xv_q[1]);
			cy_q <= pick_coef(yv_q[0], yv_q[1]);
		end
		if (st_q == ST_PICK || ph_end)
			acc_q <= '0;
		else if (prod_vld_s1)
			acc_q <= acc_q + pext;
		if (ph_end) begin
			case (phase_q)
				PH_FX: fx_q <= acc_q[FLUX_W+10:11];
				PH_FY: fy_q <= acc_q[FLUX_W+10:11];
				PH_SX: sx_q <= acc_q[FLUX_W+23:24];
				default: sy_q <= acc_q[FLUX_W+23:24];
			endcase
		end
	end

	// final subtract and saturation
	logic signed [RES_W-1:0] res;
	logic signed [31:0]      res_sat;
	logic                    out_valid_q;

	always_comb begin
		res = $signed({{(RES_W-32){dw_q[2][31]}}, dw_q[2]})
			- RES_W'(sx_q) - RES_W'(sy_q);
		if (res > RES_W'(64'sd2147483647))
			res_sat = 32'sh7fffffff;
		else if (res < -RES_W'(64'sd2147483648))
			res_sat = 32'sh80000000;
		else
			res_sat = res[31:0];
	end

	always_comb begin
		st_d   = st_q;
		rd_go  = 1'b0;
		fin_go = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (in_acc && emit)
					st_d = ST_READ;
			end
			ST_READ: begin
				rd_go = 1'b1;
				if (rd_idx_q == 3'd7)
					st_d = ST_PICK;
			end
			ST_PICK: st_d = ST_MAC;
			ST_MAC: begin
				if (ph_end && phase_q == PH_SY)
					st_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					fin_go = 1'b1;
					st_d   = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			new_density <= res_sat;
			cell_col    <= ci_q;
			cell_row    <= cj_q;
			frame_done  <= cdone_q;
		end
	end

	assign out_valid = out_valid_q;

	// read data only returns while the neighbourhood is gathered
	a_rd_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (st_q == ST_READ || st_q == ST_PICK))
		else $error("line memory read data outside gather");

	// products are only in flight during the accumulate phases
	a_prod_mac: assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_s1 |-> st_q == ST_MAC)
		else $error("product in flight outside accumulate");

	// the final subtract sees a drained datapath
	a_fin_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN |-> (!prod_vld_s1 && !rd_vld_s1))
		else $error("datapath busy at final subtract");

	// a new word on the output comes only from the final step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == ST_FIN))
		else $error("output word without final step");

	// samples are taken only when the engine is idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (st_q == ST_IDLE || st_q == ST_READ))
		else $error("unexpected state after accept");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the quick upwind density advection stencil engine
module tb_top;
	import qudadv_pkg::*;

	typedef struct packed {
		logic signed [31:0] dens;
		logic [COL_W-1:0] col;
		logic [CELL_ROW_W-1:0] row;
		logic done;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] density_sample = '0;
	logic signed [31:0] xvel_left_face = '0;
	logic signed [31:0] yvel_lower_face = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] new_density;
	logic [COL_W-1:0] cell_col;
	logic [CELL_ROW_W-1:0] cell_row;
	logic frame_done;

	quick_upwind_density_advection dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// grid state mirrored from the block
	longint dens_rows [DENS_ROWS*MAX_ROW_LENGTH];
	longint xvel_rows [VEL_ROWS*MAX_ROW_LENGTH];
	longint yvel_rows [VEL_ROWS*MAX_ROW_LENGTH];
	longint centre_win [5];
	int unsigned col_pos, row_pos;
	int unsigned reg_iw = 64, reg_ih = 64, reg_border = 2;
	longint reg_kx = 6554, reg_ky = 6554;

	cell_t expected_cells [$];
	int errors = 0;
	int idle_pct = 0, stall_pct = 0;
	int random_words = 0;

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	function automatic void eff_dims(output int unsigned b, iw, ih);
		b = reg_border < 2 ? 2 : (reg_border > 4 ? 4 : reg_border);
		iw = reg_iw > MAX_ROW_LENGTH - 2*b ? MAX_ROW_LENGTH - 2*b : reg_iw;
		ih = reg_ih > MAX_HEIGHT ? MAX_HEIGHT : reg_ih;
	endfunction

	function automatic longint fetch(int which, int unsigned slot, int unsigned col);
		if (col >= MAX_ROW_LENGTH)
			return 0;
		case (which)
			0: return dens_rows[slot*MAX_ROW_LENGTH + col];
			1: return xvel_rows[slot*MAX_ROW_LENGTH + col];
			default: return yvel_rows[slot*MAX_ROW_LENGTH + col];
		endcase
	endfunction

	// coefficients in eighths of a velocity
	function automatic void quick_coefs(output longint c[5], input longint v1, v2);
		foreach (c[k]) c[k] = 0;
		if (v1 >= 0 && v2 >= 0) begin
			c[0] = v1; c[1] = -v2 - 6*v1; c[2] = 6*v2 - 3*v1; c[3] = 3*v2;
		end else if (v1 <= 0 && v2 <= 0) begin
			c[1] = -3*v1; c[2] = 3*v2 - 6*v1; c[3] = 6*v2 + v1; c[4] = -v2;
		end else if (v1 < 0) begin
			c[1] = -v2 - 3*v1; c[2] = 6*v2 - 6*v1; c[3] = 3*v2 + v1;
		end else begin
			c[0] = v1; c[1] = -6*v1; c[2] = 3*v2 - 3*v1; c[3] = 6*v2; c[4] = -v2;
		end
	endfunction

	function automatic longint flux_sum(input longint c[5], input longint rho[5]);
		longint hi, lo, rh;
		hi = 0;
		lo = 0;
		for (int k = 0; k < 5; k++) begin
			rh = rho[k] >>> 16;
			hi += c[k] * rh;
			lo += c[k] * (rho[k] - rh * 65536);
		end
		return hi * 32 + (lo >>> 11);
	endfunction

	function automatic longint scale_flux(longint f, longint k);
		longint fh;
		fh = f >>> 24;
		return fh * k + (((f - (fh <<< 24)) * k) >>> 24);
	endfunction

	function automatic void advect_word(longint rho, u, v, bit fs);
		int unsigned b, iw, ih, pw, ph, r, c;
		longint colv[5], cx[5], cy[5], res;
		cell_t exp_word;
		eff_dims(b, iw, ih);
		pw = iw + 2*b;
		ph = ih + 2*b;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		if (r >= 2 && r-2 >= b && r-2 < b+ih && c >= b && c < b+iw) begin
			for (int k = 0; k < 5; k++)
				centre_win[k] = fetch(0, (r+2) % 4, c + k - 2);
			colv[0] = fetch(0, r % 4, c);
			colv[1] = fetch(0, (r+1) % 4, c);
			colv[2] = centre_win[2];
			colv[3] = fetch(0, (r+3) % 4, c);
			colv[4] = rho;
			quick_coefs(cx, fetch(1, r % 2, c), fetch(1, r % 2, c+1));
			quick_coefs(cy, fetch(2, r % 2, c), fetch(2, (r+1) % 2, c));
			res = centre_win[2] - scale_flux(flux_sum(cx, centre_win), reg_kx)
				- scale_flux(flux_sum(cy, colv), reg_ky);
			if (res > 64'sd2147483647) res = 64'sd2147483647;
			if (res < -64'sd2147483648) res = -64'sd2147483648;
			exp_word.dens = res[31:0];
			exp_word.col = COL_W'(c - b);
			exp_word.row = CELL_ROW_W'(r - 2 - b);
			exp_word.done = (c - b == iw - 1) && (r - 2 - b == ih - 1);
			expected_cells.push_back(exp_word);
		end
		if (c < MAX_ROW_LENGTH) begin
			dens_rows[(r % 4)*MAX_ROW_LENGTH + c] = rho;
			xvel_rows[(r % 2)*MAX_ROW_LENGTH + c] = u;
			yvel_rows[(r % 2)*MAX_ROW_LENGTH + c] = v;
		end
		c++;
		if (c >= pw) begin
			c = 0;
			r++;
			if (r >= ph) r = 0;
		end
		col_pos = c & 32'h3FF;
		row_pos = r & 32'h1FFF;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		cell_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_cells.size() == 0) begin
				report_mismatch("unexpected word, col", cell_col, -1);
			end else begin
				want = expected_cells.pop_front();
				if (new_density !== want.dens)
					report_mismatch("new_density", new_density, want.dens);
				if (cell_col !== want.col) report_mismatch("cell_col", cell_col, want.col);
				if (cell_row !== want.row) report_mismatch("cell_row", cell_row, want.row);
				if (frame_done !== want.done)
					report_mismatch("frame_done", frame_done, want.done);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IWIDTH: reg_iw = val & 32'h3FF;
			CFG_IHEIGHT: reg_ih = val & 32'h1FFF;
			CFG_BORDER: reg_border = val & 32'h7;
			CFG_DTDX: reg_kx = val & 32'hFFFFFF;
			CFG_DTDY: reg_ky = val & 32'hFFFFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_grid(int unsigned iw, ih, b, kx, ky);
		write_reg(CFG_IWIDTH, iw);
		write_reg(CFG_IHEIGHT, ih);
		write_reg(CFG_BORDER, b);
		write_reg(CFG_DTDX, kx);
		write_reg(CFG_DTDY, ky);
	endtask

	task automatic send_word(logic [31:0] rho, u, v, bit fs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		density_sample <= rho;
		xvel_left_face <= u;
		yvel_lower_face <= v;
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
		advect_word($signed(rho), $signed(u), $signed(v), fs);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_cells.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value(int extreme_pct);
		if ($urandom_range(99) < extreme_pct)
			case ($urandom_range(4))
				0: return 32'h7FFFFFFF;
				1: return 32'h80000000;
				2: return 32'h0;
				3: return 32'hFFFFFFFF;
				default: return $urandom;
			endcase
		return 32'($urandom_range(2*(1 << 20)) - (1 << 20));
	endfunction

	task automatic send_words(int n, int extreme_pct, bit first_fs);
		for (int k = 0; k < n; k++)
			send_word(pick_value(extreme_pct), pick_value(extreme_pct),
				pick_value(extreme_pct), first_fs && k == 0);
	endtask

	function automatic int grid_words();
		int unsigned b, iw, ih;
		eff_dims(b, iw, ih);
		return (iw + 2*b) * (ih + 2*b);
	endfunction

	task automatic test_extremes();
		set_grid(4, 1, 2, 24'hFFFFFF, 0);
		send_words(grid_words(), 80, 1);
		drain();
		set_grid(1, 1, 2, 0, 24'hFFFFFF);
		send_words(grid_words(), 80, 1);
		drain();
	endtask

	// border clamped both ways, then the top rows of an over-tall grid
	task automatic test_clamps();
		set_grid(3, 2, 0, 6554, 6554);
		send_words(grid_words(), 20, 1);
		drain();
		set_grid(2, 1, 7, 40000, 3000);
		send_words(grid_words(), 20, 1);
		drain();
		set_grid(1, 8191, 2, 6554, 6554);
		send_words(60, 20, 1);
		drain();
	endtask

	task automatic test_empty_grids();
		set_grid(0, 3, 2, 6554, 6554);
		send_words(grid_words(), 20, 1);
		drain();
		set_grid(5, 0, 3, 6554, 6554);
		send_words(grid_words(), 20, 1);
		drain();
	endtask

	// two grids back to back with no frame marker, then a restart part way in
	task automatic test_wrap_restart();
		set_grid(3, 2, 2, 9000, 12000);
		send_words(2*grid_words(), 20, 1);
		send_words(30, 20, 0);
		send_words(grid_words(), 20, 1);
		drain();
	endtask

	task automatic test_shrink_mid_grid();
		set_grid(8, 6, 2, 6554, 6554);
		send_words(65, 20, 1);
		drain();
		write_reg(CFG_IWIDTH, 3);
		write_reg(CFG_IHEIGHT, 2);
		send_words(40, 20, 0);
		send_words(grid_words(), 20, 1);
		drain();
	endtask

	task automatic test_random();
		int unsigned kx, ky;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = ph == 1 || ph == 3 ? (ph == 3 ? 36 : 55) : 0;
			stall_pct = ph == 2 ? 55 : (ph == 3 ? 36 : 0);
			while (random_words < (ph + 1) * 250) begin
				kx = $urandom_range(9) == 0 ? 24'hFFFFFF : $urandom_range(24'h3FFFF);
				ky = $urandom_range(9) == 0 ? 0 : $urandom_range(24'h3FFFF);
				set_grid($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(2, 4),
					kx, ky);
				for (int g = $urandom_range(1, 2); g > 0; g--) begin
					send_words(grid_words(), 8, g == 2 || $urandom_range(1));
					random_words += grid_words();
				end
				if (ph == 1 && random_words < 550) begin
					send_words(7, 8, 0);
					drain();
					send_words(grid_words() - 7, 8, 0);
					random_words += grid_words();
				end
				drain();
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_clamps();
		test_empty_grids();
		test_wrap_restart();
		test_shrink_mid_grid();
		test_random();
		drain();
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/qudadv_pkg.sv
sv/qudadv_ram.sv
sv/quick_upwind_density_advection.sv
tb/tb_top.sv
